// ===== rtl/ccwa_pkg.sv =====
// shared types, constants and arctangent table for the ccw angle core
package ccwa_pkg;

    localparam int COORD_BITS_DEF   = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // turn accumulator: 2^32 per full turn
    localparam int ACC_BITS    = 32;
    // vectors are scaled until the larger component reaches 2^NORM_MSB
    localparam int NORM_MSB    = 40;
    localparam int M_BITS      = NORM_MSB + 1;
    // headroom for cordic gain on top of the normalized magnitude
    localparam int VEC_BITS    = NORM_MSB + 5;
    // shift levels 32, 16, 8, 4, 2, 1
    localparam int NORM_LEVELS = 6;
    localparam int TAB_IDX_BITS = 5;

    localparam logic [ACC_BITS-1:0] ACC_HALF_TURN = {1'b1, {(ACC_BITS-1){1'b0}}};

    typedef logic [ACC_BITS-1:0]        t_acc;
    typedef logic signed [VEC_BITS-1:0] t_vword;

    typedef struct packed {
        t_vword x;
        t_vword y;
        t_acc   acc;
    } t_vec;

    typedef struct packed {
        logic degen;
        logic coll;
        logic same;
    } t_flags;

    // atan(2^-i) in units of 2^-32 turn, truncated
    function automatic t_acc atan_step(input logic [TAB_IDX_BITS-1:0] idx);
        t_acc res;
        case (idx)
            5'd0:    res = 32'h20000000;
            5'd1:    res = 32'h12E4051D;
            5'd2:    res = 32'h09FB385B;
            5'd3:    res = 32'h051111D4;
            5'd4:    res = 32'h028B0D43;
            5'd5:    res = 32'h0145D7E1;
            5'd6:    res = 32'h00A2F61E;
            5'd7:    res = 32'h00517C55;
            5'd8:    res = 32'h0028BE53;
            5'd9:    res = 32'h00145F2E;
            5'd10:   res = 32'h000A2F98;
            5'd11:   res = 32'h000517CC;
            5'd12:   res = 32'h00028BE6;
            5'd13:   res = 32'h000145F3;
            5'd14:   res = 32'h0000A2F9;
            5'd15:   res = 32'h0000517C;
            5'd16:   res = 32'h000028BE;
            5'd17:   res = 32'h0000145F;
            5'd18:   res = 32'h00000A2F;
            5'd19:   res = 32'h00000517;
            5'd20:   res = 32'h0000028B;
            5'd21:   res = 32'h00000145;
            5'd22:   res = 32'h000000A2;
            5'd23:   res = 32'h00000051;
            5'd24:   res = 32'h00000028;
            5'd25:   res = 32'h00000014;
            5'd26:   res = 32'h0000000A;
            5'd27:   res = 32'h00000005;
            5'd28:   res = 32'h00000002;
            5'd29:   res = 32'h00000001;
            default: res = 32'h00000000;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/ccwa_if.sv =====
// request and result channel interfaces of the ccw angle core
interface ccwa_in_if #(
    parameter int COORD_BITS = ccwa_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ux;
    logic signed [COORD_BITS-1:0] uy;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] wx;
    logic signed [COORD_BITS-1:0] wy;

    modport source (output valid, ux, uy, vx, vy, wx, wy, input ready);
    modport sink   (input valid, ux, uy, vx, vy, wx, wy, output ready);
endinterface

interface ccwa_out_if #(
    parameter int ANGLE_BITS = ccwa_pkg::ANGLE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] ccw_angle;
    logic                  degenerate;

    modport source (output valid, ccw_angle, degenerate, input ready);
    modport sink   (input valid, ccw_angle, degenerate, output ready);
endinterface

// ===== rtl/ccwa_prep.sv =====
// difference vectors, degenerate and collinear detection, half-plane folding
module ccwa_prep #(
    parameter int COORD_BITS = ccwa_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_ux,
    input  logic signed [COORD_BITS-1:0] i_uy,
    input  logic signed [COORD_BITS-1:0] i_vx,
    input  logic signed [COORD_BITS-1:0] i_vy,
    input  logic signed [COORD_BITS-1:0] i_wx,
    input  logic signed [COORD_BITS-1:0] i_wy,
    output logic                         o_valid,
    input  logic                         i_ready,
    output ccwa_pkg::t_vec               o_vec [2],
    output ccwa_pkg::t_flags             o_flags
);
    import ccwa_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    logic signed [DIFF_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    logic                        r_degen1;

    logic signed [PROD_BITS-1:0] r_p1, r_p2;
    t_vec                        r_vec2 [2];
    logic                        r_degen2, r_same2;

    t_vec                        r_vec3 [2];
    t_flags                      r_flags3;

    logic signed [PROD_BITS-1:0] n_p1, n_p2;
    t_vec                        n_vec2 [2];
    logic                        n_same2;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // stage 2: cross products, sign match, fold left half plane
    always_comb begin
        t_vword xa, ya, xb, yb;
        n_p1 = PROD_BITS'(r_ax) * PROD_BITS'(r_by);
        n_p2 = PROD_BITS'(r_ay) * PROD_BITS'(r_bx);
        n_same2 = ((r_ax < 0) == (r_bx < 0)) && ((r_ax == 0) == (r_bx == 0)) &&
                  ((r_ay < 0) == (r_by < 0)) && ((r_ay == 0) == (r_by == 0));
        xa = VEC_BITS'(r_ax);
        ya = VEC_BITS'(r_ay);
        xb = VEC_BITS'(r_bx);
        yb = VEC_BITS'(r_by);
        n_vec2[0].x   = (r_ax < 0) ? -xa : xa;
        n_vec2[0].y   = (r_ax < 0) ? -ya : ya;
        n_vec2[0].acc = (r_ax < 0) ? ACC_HALF_TURN : '0;
        n_vec2[1].x   = (r_bx < 0) ? -xb : xb;
        n_vec2[1].y   = (r_bx < 0) ? -yb : yb;
        n_vec2[1].acc = (r_bx < 0) ? ACC_HALF_TURN : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_ax     <= DIFF_BITS'(i_ux) - DIFF_BITS'(i_vx);
            r_ay     <= DIFF_BITS'(i_uy) - DIFF_BITS'(i_vy);
            r_bx     <= DIFF_BITS'(i_wx) - DIFF_BITS'(i_vx);
            r_by     <= DIFF_BITS'(i_wy) - DIFF_BITS'(i_vy);
            r_degen1 <= ((i_ux == i_vx) && (i_uy == i_vy)) ||
                        ((i_wx == i_vx) && (i_wy == i_vy));
        end
        if (w_rdy2 && r_v1) begin
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_vec2   <= n_vec2;
            r_degen2 <= r_degen1;
            r_same2  <= n_same2;
        end
        if (w_rdy3 && r_v2) begin
            r_vec3         <= r_vec2;
            r_flags3.degen <= r_degen2;
            r_flags3.coll  <= (r_p1 == r_p2);
            r_flags3.same  <= r_same2;
        end
    end

    assign o_valid = r_v3;
    assign o_vec   = r_vec3;
    assign o_flags = r_flags3;

endmodule

// ===== rtl/ccwa_norm.sv =====
// magnitude search and power-of-two scaling of both vectors, two levels a stage
module ccwa_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ccwa_pkg::t_vec   i_vec [2],
    input  ccwa_pkg::t_flags i_flags,
    output logic             o_valid,
    input  logic             i_ready,
    output ccwa_pkg::t_vec   o_vec [2],
    output ccwa_pkg::t_flags o_flags
);
    import ccwa_pkg::*;

    localparam int NSTG = (NORM_LEVELS + 1) / 2;

    logic              r_v     [NSTG+1];
    t_vec              r_vec   [NSTG+1][2];
    logic [M_BITS-1:0] r_m     [NSTG+1][2];
    t_flags            r_flags [NSTG+1];
    logic              w_rdy   [NSTG+2];

    t_vec              n_vec   [NSTG+1][2];
    logic [M_BITS-1:0] n_m     [NSTG+1][2];

    assign w_rdy[NSTG+1] = i_ready;
    for (genvar s = 0; s <= NSTG; s++) begin : g_rdy
        assign w_rdy[s] = !r_v[s] || w_rdy[s+1];
    end
    assign o_ready = w_rdy[0];

    always_comb begin
        t_vword            ay;
        logic [M_BITS-1:0] m;
        t_vword            x, y;
        int                k;
        k = 0;
        // stage 0: larger component magnitude (x is already non-negative)
        for (int l = 0; l < 2; l++) begin
            ay = (i_vec[l].y < 0) ? -i_vec[l].y : i_vec[l].y;
            n_m[0][l]   = (i_vec[l].x > ay) ? M_BITS'(i_vec[l].x) : M_BITS'(ay);
            n_vec[0][l] = i_vec[l];
        end
        // later stages: shift by k while the magnitude stays below 2^(NORM_MSB+1)
        for (int s = 1; s <= NSTG; s++) begin
            for (int l = 0; l < 2; l++) begin
                m = r_m[s-1][l];
                x = r_vec[s-1][l].x;
                y = r_vec[s-1][l].y;
                for (int j = 2 * (s - 1); j < 2 * s; j++) begin
                    if (j < NORM_LEVELS) begin
                        k = 1 << (NORM_LEVELS - 1 - j);
                        if ((m >> (M_BITS - k)) == '0) begin
                            m = m << k;
                            x = x <<< k;
                            y = y <<< k;
                        end
                    end
                end
                n_m[s][l]       = m;
                n_vec[s][l].x   = x;
                n_vec[s][l].y   = y;
                n_vec[s][l].acc = r_vec[s-1][l].acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NSTG; s++) r_v[s] <= 1'b0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int s = 1; s <= NSTG; s++) begin
                if (w_rdy[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_vec[0]   <= n_vec[0];
            r_m[0]     <= n_m[0];
            r_flags[0] <= i_flags;
        end
        for (int s = 1; s <= NSTG; s++) begin
            if (w_rdy[s] && r_v[s-1]) begin
                r_vec[s]   <= n_vec[s];
                r_m[s]     <= n_m[s];
                r_flags[s] <= r_flags[s-1];
            end
        end
    end

    assign o_valid = r_v[NSTG];
    assign o_vec   = r_vec[NSTG];
    assign o_flags = r_flags[NSTG];

    // a nonzero vector always leaves with its top magnitude bit set
    a_norm_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG] && !r_flags[NSTG].degen |->
            r_m[NSTG][0][NORM_MSB] && r_m[NSTG][1][NORM_MSB])
        else $error("normalized magnitude out of range");

endmodule

// ===== rtl/ccwa_cordic.sv =====
// vectoring cordic, one micro-rotation per stage, two lanes side by side
module ccwa_cordic #(
    parameter int CORDIC_STEPS = ccwa_pkg::CORDIC_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ccwa_pkg::t_vec   i_vec [2],
    input  ccwa_pkg::t_flags i_flags,
    output logic             o_valid,
    input  logic             i_ready,
    output ccwa_pkg::t_acc   o_acc [2],
    output ccwa_pkg::t_flags o_flags
);
    import ccwa_pkg::*;

    logic   r_v     [CORDIC_STEPS];
    t_vec   r_vec   [CORDIC_STEPS][2];
    t_flags r_flags [CORDIC_STEPS];
    logic   w_rdy   [CORDIC_STEPS+1];
    t_vec   n_vec   [CORDIC_STEPS][2];

    assign w_rdy[CORDIC_STEPS] = i_ready;
    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_rdy
        assign w_rdy[s] = !r_v[s] || w_rdy[s+1];
    end
    assign o_ready = w_rdy[0];

    always_comb begin
        t_vec   src;
        t_vword x, y, xs, ys;
        t_acc   da;
        for (int s = 0; s < CORDIC_STEPS; s++) begin
            da = atan_step(TAB_IDX_BITS'(s));
            for (int l = 0; l < 2; l++) begin
                src = (s == 0) ? i_vec[l] : r_vec[(s == 0) ? 0 : s - 1][l];
                x   = src.x;
                y   = src.y;
                xs  = x >>> s;
                ys  = y >>> s;
                // rotate toward the positive x axis
                if (y < 0) begin
                    n_vec[s][l].x   = x - ys;
                    n_vec[s][l].y   = y + xs;
                    n_vec[s][l].acc = src.acc - da;
                end else begin
                    n_vec[s][l].x   = x + ys;
                    n_vec[s][l].y   = y - xs;
                    n_vec[s][l].acc = src.acc + da;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < CORDIC_STEPS; s++) r_v[s] <= 1'b0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int s = 1; s < CORDIC_STEPS; s++) begin
                if (w_rdy[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_vec[0]   <= n_vec[0];
            r_flags[0] <= i_flags;
        end
        for (int s = 1; s < CORDIC_STEPS; s++) begin
            if (w_rdy[s] && r_v[s-1]) begin
                r_vec[s]   <= n_vec[s];
                r_flags[s] <= r_flags[s-1];
            end
        end
    end

    assign o_valid  = r_v[CORDIC_STEPS-1];
    assign o_acc[0] = r_vec[CORDIC_STEPS-1][0].acc;
    assign o_acc[1] = r_vec[CORDIC_STEPS-1][1].acc;
    assign o_flags  = r_flags[CORDIC_STEPS-1];

endmodule

// ===== rtl/ccwa_out.sv =====
// angle difference, rounding to the output width, special cases, result register
module ccwa_out #(
    parameter int ANGLE_BITS = ccwa_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ccwa_pkg::t_acc        i_acc [2],
    input  ccwa_pkg::t_flags      i_flags,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ANGLE_BITS-1:0] o_angle,
    output logic                  o_degen
);
    import ccwa_pkg::*;

    localparam int RND_SHIFT = ACC_BITS - ANGLE_BITS;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    logic                  r_v1, r_v2;
    logic                  w_rdy1, w_rdy2;
    t_acc                  r_d;
    t_flags                r_flags1;
    logic [ANGLE_BITS-1:0] r_angle;
    logic                  r_degen;
    logic [ANGLE_BITS-1:0] w_round;
    logic [ANGLE_BITS-1:0] n_angle;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // round half up; a carry past one turn wraps to zero
    if (RND_SHIFT > 0) begin : g_rnd
        localparam t_acc RND_HALF = t_acc'(1) << (RND_SHIFT - 1);
        t_acc w_sum;
        assign w_sum   = r_d + RND_HALF;
        assign w_round = w_sum[ACC_BITS-1:RND_SHIFT];
    end else begin : g_nornd
        assign w_round = r_d[ANGLE_BITS-1:0];
    end

    always_comb begin
        if (r_flags1.degen) begin
            n_angle = '0;
        end else if (r_flags1.coll) begin
            n_angle = r_flags1.same ? '0 : HALF_TURN;
        end else begin
            n_angle = w_round;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_d      <= i_acc[1] - i_acc[0];
            r_flags1 <= i_flags;
        end
        if (w_rdy2 && r_v1) begin
            r_angle <= n_angle;
            r_degen <= r_flags1.degen;
        end
    end

    assign o_valid = r_v2;
    assign o_angle = r_angle;
    assign o_degen = r_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_degen |-> r_angle == '0)
        else $error("degenerate result with nonzero angle");

    a_same_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && w_rdy2 && !r_flags1.degen && r_flags1.coll && r_flags1.same
            |=> r_angle == '0)
        else $error("same direction did not give zero");

    a_opp_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && w_rdy2 && !r_flags1.degen && r_flags1.coll && !r_flags1.same
            |=> r_angle == HALF_TURN && !r_degen)
        else $error("opposite direction did not give half a turn");

endmodule

// ===== rtl/ccw_angle_three_points_core.sv =====
// Counterclockwise angle at vertex v from ray v->u to ray v->w, as a binary angle
// (2^ANGLE_BITS per turn); u or w equal to v flags degenerate with angle 0. The core
// accepts one request per clock unless a stalled result channel has filled every stage:
// three stages form the differences, cross products and half-plane fold, four stages
// search the magnitude and scale both vectors, one stage per CORDIC micro-rotation
// follows, and two stages take the difference, round and hold the result. Every stage
// has its own valid bit, so a stalled result register still lets requests flow into
// the empty stages behind it; ready is a combinational chain from the result channel
// back to the request channel.
module ccw_angle_three_points_core #(
    parameter int COORD_BITS   = ccwa_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS   = ccwa_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = ccwa_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ccwa_in_if.sink           i_req,
    ccwa_out_if.source        o_res
);
    import ccwa_pkg::*;

    logic   w_prep_valid, w_prep_ready;
    t_vec   w_prep_vec [2];
    t_flags w_prep_flags;

    logic   w_norm_valid, w_norm_ready;
    t_vec   w_norm_vec [2];
    t_flags w_norm_flags;

    logic   w_cdc_valid, w_cdc_ready;
    t_acc   w_cdc_acc [2];
    t_flags w_cdc_flags;

    logic   w_in_ready;
    logic   w_out_valid;
    logic   [ANGLE_BITS-1:0] w_angle;
    logic   w_degen;

    ccwa_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (w_in_ready),
        .i_ux    (i_req.ux),
        .i_uy    (i_req.uy),
        .i_vx    (i_req.vx),
        .i_vy    (i_req.vy),
        .i_wx    (i_req.wx),
        .i_wy    (i_req.wy),
        .o_valid (w_prep_valid),
        .i_ready (w_prep_ready),
        .o_vec   (w_prep_vec),
        .o_flags (w_prep_flags)
    );

    ccwa_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prep_valid),
        .o_ready (w_prep_ready),
        .i_vec   (w_prep_vec),
        .i_flags (w_prep_flags),
        .o_valid (w_norm_valid),
        .i_ready (w_norm_ready),
        .o_vec   (w_norm_vec),
        .o_flags (w_norm_flags)
    );

    ccwa_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_norm_valid),
        .o_ready (w_norm_ready),
        .i_vec   (w_norm_vec),
        .i_flags (w_norm_flags),
        .o_valid (w_cdc_valid),
        .i_ready (w_cdc_ready),
        .o_acc   (w_cdc_acc),
        .o_flags (w_cdc_flags)
    );

    ccwa_out #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cdc_valid),
        .o_ready (w_cdc_ready),
        .i_acc   (w_cdc_acc),
        .i_flags (w_cdc_flags),
        .o_valid (w_out_valid),
        .i_ready (o_res.ready),
        .o_angle (w_angle),
        .o_degen (w_degen)
    );

    assign i_req.ready      = w_in_ready;
    assign o_res.valid      = w_out_valid;
    assign o_res.ccw_angle  = w_angle;
    assign o_res.degenerate = w_degen;

endmodule

// ===== verif/ccw_angle_three_points_core_tb.sv =====
// self-checking testbench for the ccw angle core: directed table, then random point triples
module ccw_angle_three_points_core_tb;

    localparam int COORD_W  = ccwa_pkg::COORD_BITS_DEF;
    localparam int ANGLE_W  = ccwa_pkg::ANGLE_BITS_DEF;
    localparam int STEPS    = ccwa_pkg::CORDIC_STEPS_DEF;
    localparam int TURN_W   = 32;
    localparam int N_RANDOM = 1800;
    localparam int N_ROWS   = 23;

    localparam logic [ANGLE_W-1:0] HALF_TURN = {1'b1, {(ANGLE_W-1){1'b0}}};

    // atan(2^-i) in 2^-32 turn units, truncated
    localparam logic [TURN_W-1:0] TURN_STEP [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    localparam int CORNERS [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    typedef struct packed {
        logic signed [COORD_W-1:0] ux;
        logic signed [COORD_W-1:0] uy;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] wx;
        logic signed [COORD_W-1:0] wy;
    } t_point_triple;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               degen;
    } t_angle_result;

    typedef struct packed {
        t_point_triple      pt;
        bit                 typed;
        logic [ANGLE_W-1:0] angle;
        bit                 degen;
    } t_stim_row;

    // expected result typed in only for degenerate and collinear rows
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        '{'{0, 0, 0, 0, 0, 0},                                  1'b1, 0, 1'b1},
        '{'{5, 7, 5, 7, 100, -3},                               1'b1, 0, 1'b1},
        '{'{-32768, 32767, 1200, -40, 1200, -40},               1'b1, 0, 1'b1},
        '{'{32767, 32767, 32767, 32767, -32768, -32768},        1'b1, 0, 1'b1},
        '{'{1, 0, 0, 0, 2, 0},                                  1'b1, 0, 1'b0},
        '{'{1, 0, 0, 0, -1, 0},                                 1'b1, HALF_TURN, 1'b0},
        '{'{0, -10, 0, 0, 0, 10},                               1'b1, HALF_TURN, 1'b0},
        '{'{32767, 32767, 0, 0, -32768, -32768},                1'b1, HALF_TURN, 1'b0},
        '{'{32767, 32767, -32768, -32768, 0, 0},                1'b1, 0, 1'b0},
        '{'{-32768, 32767, 32767, -32768, -32768, 32767},       1'b1, 0, 1'b0},
        '{'{1, 1, 0, 0, -1, -1},                                1'b1, HALF_TURN, 1'b0},
        '{'{32767, -32768, -32768, -32768, -32768, 32767},      1'b0, 0, 1'b0},
        '{'{0, 10, 0, 0, -10, 0},                               1'b0, 0, 1'b0},
        '{'{-10, 0, 0, 0, 0, 10},                               1'b0, 0, 1'b0},
        '{'{32767, 0, 0, 0, 32767, -1},                         1'b0, 0, 1'b0},
        '{'{32767, 1, 0, 0, 32767, 0},                          1'b0, 0, 1'b0},
        '{'{32767, 0, 0, 0, 32767, 1},                          1'b0, 0, 1'b0},
        '{'{-5, 3, 0, 0, -7, -2},                               1'b0, 0, 1'b0},
        '{'{3, -4, -1, 2, -6, 9},                               1'b0, 0, 1'b0},
        '{'{-32768, -32768, 32767, 32767, 32767, -32768},       1'b0, 0, 1'b0},
        '{'{0, -1, 0, 0, 1, 0},                                 1'b0, 0, 1'b0},
        '{'{-1, 0, 0, 0, 0, -1},                                1'b0, 0, 1'b0},
        '{'{-32768, 0, 32767, 0, 32767, -32768},                1'b0, 0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    ccwa_in_if  #(.COORD_BITS(COORD_W)) req_if ();
    ccwa_out_if #(.ANGLE_BITS(ANGLE_W)) res_if ();

    ccw_angle_three_points_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_angle_result pending_results [$];
    int  fail_count = 0;
    int  n_sent     = 0;
    int  n_checked  = 0;
    int  n_degen    = 0;
    int  n_zero     = 0;
    int  n_half     = 0;
    bit  no_idle    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int sign_of(input longint a);
        return (a > 0) ? 1 : ((a < 0) ? -1 : 0);
    endfunction

    // binary angle of a nonzero ray, 2^32 per turn
    function automatic logic [TURN_W-1:0] ray_turn(input longint rx, input longint ry);
        logic [TURN_W-1:0] turn;
        longint            big;
        longint            ry_mag;
        longint            xs;
        longint            ys;
        turn = '0;
        // fold the left half plane onto the right one
        if (rx < 0) begin
            rx   = -rx;
            ry   = -ry;
            turn = 32'h8000_0000;
        end
        ry_mag = (ry < 0) ? -ry : ry;
        big    = (rx > ry_mag) ? rx : ry_mag;
        while (big != 0 && big < (longint'(1) << 40)) begin
            big = big <<< 1;
            rx  = rx <<< 1;
            ry  = ry <<< 1;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = rx >>> i;
            ys = ry >>> i;
            if (ry < 0) begin
                rx   = rx - ys;
                ry   = ry + xs;
                turn = turn - TURN_STEP[i];
            end else begin
                rx   = rx + ys;
                ry   = ry - xs;
                turn = turn + TURN_STEP[i];
            end
        end
        return turn;
    endfunction

    function automatic t_angle_result predict_ccw_angle(input t_point_triple p);
        t_angle_result     res;
        longint            ax;
        longint            ay;
        longint            bx;
        longint            by;
        logic [TURN_W-1:0] diff;
        logic [63:0]       rounded;
        ax = longint'($signed(p.ux)) - longint'($signed(p.vx));
        ay = longint'($signed(p.uy)) - longint'($signed(p.vy));
        bx = longint'($signed(p.wx)) - longint'($signed(p.vx));
        by = longint'($signed(p.wy)) - longint'($signed(p.vy));
        res.degen = 1'b0;
        if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
            res.angle = '0;
            res.degen = 1'b1;
        end else if (ax * by == ay * bx) begin
            if (sign_of(ax) == sign_of(bx) && sign_of(ay) == sign_of(by))
                res.angle = '0;
            else
                res.angle = HALF_TURN;
        end else begin
            diff    = ray_turn(bx, by) - ray_turn(ax, ay);
            rounded = ({32'd0, diff} + (64'd1 << (TURN_W - ANGLE_W - 1)))
                      >> (TURN_W - ANGLE_W);
            res.angle = rounded[ANGLE_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] corner_coord();
        if ($urandom_range(0, 3) == 0)
            return COORD_W'($urandom());
        return COORD_W'(CORNERS[$urandom_range(0, 6)]);
    endfunction

    task automatic send_request(input t_point_triple pt, input t_angle_result want);
        int gap;
        int roll;
        req_if.valid <= 1'b1;
        req_if.ux    <= pt.ux;
        req_if.uy    <= pt.uy;
        req_if.vx    <= pt.vx;
        req_if.vy    <= pt.vy;
        req_if.wx    <= pt.wx;
        req_if.wy    <= pt.wy;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(want);
        n_sent++;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 70)
            gap = 0;
        else if (roll < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side backpressure
    initial begin : result_sink
        int hold;
        int roll;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (no_idle) begin
                hold = 0;
                res_if.ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    hold = $urandom_range(0, 2);
                    res_if.ready <= 1'b0;
                end else if (roll < 14) begin
                    hold = $urandom_range(20, 60);
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_angle_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: angle %0d degenerate %0b",
                             res_if.ccw_angle, res_if.degenerate);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (want.degen)
                    n_degen++;
                else if (want.angle == '0)
                    n_zero++;
                else if (want.angle == HALF_TURN)
                    n_half++;
                if (res_if.ccw_angle !== want.angle || res_if.degenerate !== want.degen) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d: expected angle %0d degenerate %0b, got %0d %0b",
                                 n_checked, want.angle, want.degen,
                                 res_if.ccw_angle, res_if.degenerate);
                end
            end
        end
    end

    initial begin : stimulus
        t_point_triple pt;
        t_angle_result want;
        int            mode;
        int            cx;
        int            cy;
        int            dx;
        int            dy;
        int            k;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.ux    <= '0;
        req_if.uy    <= '0;
        req_if.vx    <= '0;
        req_if.vy    <= '0;
        req_if.wx    <= '0;
        req_if.wy    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            pt = DIRECTED_ROWS[r].pt;
            if (DIRECTED_ROWS[r].typed) begin
                want.angle = DIRECTED_ROWS[r].angle;
                want.degen = DIRECTED_ROWS[r].degen;
            end else begin
                want = predict_ccw_angle(pt);
            end
            send_request(pt, want);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // bursts with no idling on either side
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 99);
            if (mode < 50) begin
                pt.ux = COORD_W'($urandom());
                pt.uy = COORD_W'($urandom());
                pt.vx = COORD_W'($urandom());
                pt.vy = COORD_W'($urandom());
                pt.wx = COORD_W'($urandom());
                pt.wy = COORD_W'($urandom());
            end else if (mode < 65) begin
                // short rays: coarse directions, frequent ties
                cx = int'($urandom_range(0, 60000)) - 30000;
                cy = int'($urandom_range(0, 60000)) - 30000;
                pt.vx = COORD_W'(cx);
                pt.vy = COORD_W'(cy);
                pt.ux = COORD_W'(cx + int'($urandom_range(0, 16)) - 8);
                pt.uy = COORD_W'(cy + int'($urandom_range(0, 16)) - 8);
                pt.wx = COORD_W'(cx + int'($urandom_range(0, 16)) - 8);
                pt.wy = COORD_W'(cy + int'($urandom_range(0, 16)) - 8);
            end else if (mode < 75) begin
                // collinear rays, same or opposite direction
                cx = int'($urandom_range(0, 20000)) - 10000;
                cy = int'($urandom_range(0, 20000)) - 10000;
                dx = int'($urandom_range(0, 200)) - 100;
                dy = int'($urandom_range(0, 200)) - 100;
                if (dx == 0 && dy == 0)
                    dx = 1;
                k = int'($urandom_range(0, 400)) - 200;
                pt.vx = COORD_W'(cx);
                pt.vy = COORD_W'(cy);
                pt.ux = COORD_W'(cx + dx);
                pt.uy = COORD_W'(cy + dy);
                pt.wx = COORD_W'(cx + k * dx);
                pt.wy = COORD_W'(cy + k * dy);
            end else if (mode < 80) begin
                pt.ux = COORD_W'($urandom());
                pt.uy = COORD_W'($urandom());
                pt.vx = COORD_W'($urandom());
                pt.vy = COORD_W'($urandom());
                pt.wx = COORD_W'($urandom());
                pt.wy = COORD_W'($urandom());
                if ($urandom_range(0, 1) == 0) begin
                    pt.ux = pt.vx;
                    pt.uy = pt.vy;
                end else begin
                    pt.wx = pt.vx;
                    pt.wy = pt.vy;
                end
            end else begin
                pt.ux = corner_coord();
                pt.uy = corner_coord();
                pt.vx = corner_coord();
                pt.vy = corner_coord();
                pt.wx = corner_coord();
                pt.wy = corner_coord();
            end
            send_request(pt, predict_ccw_angle(pt));
        end

        no_idle = 1'b0;
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("sent %0d requests (%0d from the directed table), checked %0d results",
                 n_sent, N_ROWS, n_checked);
        $display("degenerate %0d, zero angle %0d, half turn %0d, failures %0d",
                 n_degen, n_zero, n_half, fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #6400000;
        $display("simulation failed");
        $finish;
    end

endmodule
